// File: src/cht_pkg.sv
// ---------------------------------------------------------------------------
// cht_pkg
// Shared widths, codes, record layout and controller states for the
// coalesced hash table.
// ---------------------------------------------------------------------------
package cht_pkg;

    localparam int KEY_W          = 16;
    localparam int VAL_W          = 8;
    localparam int TAG_W          = 64;
    localparam int STATUS_W       = 2;
    localparam int SLOT_W         = 4;
    localparam int DEF_TABLE_SIZE = 16;

    // opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    // one stored record
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] mood;
        logic [VAL_W-1:0] stress;
        logic [TAG_W-1:0] tag;
    } t_record;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_CHECK,
        S_WALK,
        S_CMP,
        S_SCAN
    } t_state;

endpackage

// File: src/coalesced_hash_table.sv
// ---------------------------------------------------------------------------
// coalesced_hash_table
// Fixed table with coalesced chaining: insert a record or search by key.
// ---------------------------------------------------------------------------
// Pulse start while busy is low to issue one command; exactly one result word
// comes back on o_done for a single cycle and must be captured then, since
// the block cannot be held off. One command runs at a time. Timing is set
// by the home slot unit and by the memory read on every chain step: the home
// slot is a registered mask for a power-of-two TABLE_SIZE and otherwise a
// registered reciprocal product followed by a registered remainder, each
// slot visited on a chain is read and then used, and an insert that has to
// chain also waits for the free slot scan, which looks at one slot per cycle
// while the chain is walked. busy drops in the cycle the result is shown,
// so the next command may start right then.
// ---------------------------------------------------------------------------
module coalesced_hash_table
    import cht_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_opcode,
    input  logic [KEY_W-1:0]    i_entry_key,
    input  logic [VAL_W-1:0]    i_mood_value,
    input  logic [VAL_W-1:0]    i_stress_value,
    input  logic [TAG_W-1:0]    i_time_tag,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [VAL_W-1:0]    o_found_mood,
    output logic [VAL_W-1:0]    o_found_stress,
    output logic [TAG_W-1:0]    o_found_tag,
    output logic [SLOT_W-1:0]   o_slot_used
);

    localparam int IW = $clog2(TABLE_SIZE);

    t_state                r_state, n_state;
    logic                  r_op;
    logic [KEY_W-1:0]      r_key;
    logic [VAL_W-1:0]      r_mood;
    logic [VAL_W-1:0]      r_stress;
    logic [TAG_W-1:0]      r_tag;
    logic [IW-1:0]         r_cur, n_cur;
    logic [TABLE_SIZE-1:0] r_slot_valid, n_slot_valid;
    logic [TABLE_SIZE-1:0] r_link_valid, n_link_valid;
    logic                  r_done, n_done;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [VAL_W-1:0]      r_f_mood, n_f_mood;
    logic [VAL_W-1:0]      r_f_stress, n_f_stress;
    logic [TAG_W-1:0]      r_f_tag, n_f_tag;
    logic [SLOT_W-1:0]     r_slot, n_slot;

    logic                  w_accept;
    logic                  w_home_done;
    logic [IW-1:0]         w_home;
    logic                  w_scan_done;
    logic                  w_scan_found;
    logic [IW-1:0]         w_scan_slot;
    logic                  w_rec_we;
    logic [IW-1:0]         w_rec_addr;
    t_record               w_rec_wdata;
    logic                  w_link_we;
    t_record               w_rec_q;
    logic [IW-1:0]         w_link_q;
    logic [IW+SLOT_W-1:0]  w_cur_ext;
    logic [IW+SLOT_W-1:0]  w_free_ext;

    assign w_accept    = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign w_rec_wdata = '{key: r_key, mood: r_mood, stress: r_stress, tag: r_tag};
    assign w_cur_ext   = {{SLOT_W{1'b0}}, r_cur};
    assign w_free_ext  = {{SLOT_W{1'b0}}, w_scan_slot};

    // home slot
    cht_home_mod #(
        .TABLE_SIZE (TABLE_SIZE),
        .IW         (IW)
    ) u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_key   (i_entry_key),
        .o_done  (w_home_done),
        .o_home  (w_home)
    );

    // lowest free slot, searched alongside the chain walk
    cht_free_scan #(
        .TABLE_SIZE (TABLE_SIZE),
        .IW         (IW)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_accept),
        .i_slot_valid (r_slot_valid),
        .o_done       (w_scan_done),
        .o_found      (w_scan_found),
        .o_slot       (w_scan_slot)
    );

    // record and link memories, read at the current chain slot
    cht_mem #(
        .TABLE_SIZE (TABLE_SIZE),
        .IW         (IW)
    ) u_mem (
        .i_clk        (i_clk),
        .i_rd_addr    (r_cur),
        .i_rec_we     (w_rec_we),
        .i_rec_addr   (w_rec_addr),
        .i_rec_wdata  (w_rec_wdata),
        .i_link_we    (w_link_we),
        .i_link_addr  (r_cur),
        .i_link_wdata (w_scan_slot),
        .o_rec_q      (w_rec_q),
        .o_link_q     (w_link_q)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_valid <= '0;
            r_link_valid <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot_valid <= n_slot_valid;
            r_link_valid <= n_link_valid;
            r_done       <= n_done;
        end
    end

    // command word, chain position and result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_opcode;
            r_key    <= i_entry_key;
            r_mood   <= i_mood_value;
            r_stress <= i_stress_value;
            r_tag    <= i_time_tag;
        end
        r_cur      <= n_cur;
        r_status   <= n_status;
        r_f_mood   <= n_f_mood;
        r_f_stress <= n_f_stress;
        r_f_tag    <= n_f_tag;
        r_slot     <= n_slot;
    end

    // next state and memory writes
    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_slot_valid = r_slot_valid;
        n_link_valid = r_link_valid;
        n_done       = 1'b0;
        n_status     = r_status;
        n_f_mood     = r_f_mood;
        n_f_stress   = r_f_stress;
        n_f_tag      = r_f_tag;
        n_slot       = r_slot;
        w_rec_we     = 1'b0;
        w_rec_addr   = r_cur;
        w_link_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_HASH;
                end
            end

            S_HASH: begin
                if (w_home_done) begin
                    n_cur   = w_home;
                    n_state = S_CHECK;
                end
            end

            // memory read of r_cur is under way this cycle
            S_CHECK: begin
                if (!r_slot_valid[r_cur]) begin
                    // empty home slot
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                    n_f_mood   = '0;
                    n_f_stress = '0;
                    n_f_tag    = '0;
                    if (r_op == OP_INSERT) begin
                        w_rec_we            = 1'b1;
                        n_slot_valid[r_cur] = 1'b1;
                        n_link_valid[r_cur] = 1'b0;
                        n_status            = ST_ADDED;
                        n_slot              = w_cur_ext[SLOT_W-1:0];
                    end else begin
                        n_status = ST_MISSING;
                        n_slot   = '0;
                    end
                end else if (r_op == OP_SEARCH) begin
                    n_state = S_CMP;
                end else if (r_link_valid[r_cur]) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_SCAN;
                end
            end

            // follow one link toward the chain end
            S_WALK: begin
                n_cur   = w_link_q;
                n_state = S_CHECK;
            end

            // compare the key of the slot just read
            S_CMP: begin
                if (w_rec_q.key == r_key) begin
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                    n_status   = ST_FOUND;
                    n_f_mood   = w_rec_q.mood;
                    n_f_stress = w_rec_q.stress;
                    n_f_tag    = w_rec_q.tag;
                    n_slot     = w_cur_ext[SLOT_W-1:0];
                end else if (!r_link_valid[r_cur]) begin
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                    n_status   = ST_MISSING;
                    n_f_mood   = '0;
                    n_f_stress = '0;
                    n_f_tag    = '0;
                    n_slot     = '0;
                end else begin
                    n_cur   = w_link_q;
                    n_state = S_CHECK;
                end
            end

            // chain end reached: place the record in the free slot, or report full
            S_SCAN: begin
                if (w_scan_done) begin
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                    n_f_mood   = '0;
                    n_f_stress = '0;
                    n_f_tag    = '0;
                    if (w_scan_found) begin
                        w_rec_we                  = 1'b1;
                        w_rec_addr                = w_scan_slot;
                        w_link_we                 = 1'b1;
                        n_slot_valid[w_scan_slot] = 1'b1;
                        n_link_valid[w_scan_slot] = 1'b0;
                        n_link_valid[r_cur]       = 1'b1;
                        n_status                  = ST_ADDED;
                        n_slot                    = w_free_ext[SLOT_W-1:0];
                    end else begin
                        n_status = ST_FULL;
                        n_slot   = '0;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_found_mood   = r_f_mood;
    assign o_found_stress = r_f_stress;
    assign o_found_tag    = r_f_tag;
    assign o_slot_used    = r_slot;

endmodule

// File: src/cht_home_mod.sv
// ---------------------------------------------------------------------------
// cht_home_mod
// Home slot unit: key modulo table size. A power-of-two size is a registered
// mask; any other size multiplies by a fixed reciprocal for the quotient,
// then subtracts quotient times size, with each step registered.
// ---------------------------------------------------------------------------
module cht_home_mod
    import cht_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int IW         = $clog2(TABLE_SIZE)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_done,
    output logic [IW-1:0]    o_home
);

    localparam bit IS_POW2 = (TABLE_SIZE == (1 << IW));

    logic [IW-1:0] r_home;
    logic          r_done;

    generate
        if (IS_POW2) begin : g_mask
            // low bits of the key are the remainder
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_home <= i_key[IW-1:0];
                end
            end
        end else begin : g_recip
            // quotient = (key * ceil(2^(KEY_W+IW) / size)) >> (KEY_W+IW), exact for any key
            localparam int SH      = KEY_W + IW;
            localparam int MUL_W   = KEY_W + 1;
            localparam int PROD_W  = KEY_W + MUL_W;
            localparam int RECIP_I = ((1 << SH) + TABLE_SIZE - 1) / TABLE_SIZE;
            localparam logic [MUL_W-1:0] RECIP  = MUL_W'(RECIP_I);
            localparam logic [KEY_W-1:0] SIZE_C = KEY_W'(TABLE_SIZE);

            logic [KEY_W-1:0]     r_key;
            logic [PROD_W-1:0]    r_prod;
            logic                 r_stage;
            logic [PROD_W-SH-1:0] w_quot;
            logic [KEY_W-1:0]     w_qn;
            logic [KEY_W-1:0]     w_rem;

            // remainder from the registered product
            assign w_quot = r_prod[PROD_W-1:SH];
            assign w_qn   = KEY_W'(w_quot) * SIZE_C;
            assign w_rem  = r_key - w_qn;

            // stage one: reciprocal product, stage two: remainder
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_stage <= 1'b0;
                    r_done  <= 1'b0;
                end else begin
                    r_stage <= i_start;
                    r_done  <= r_stage;
                end
                if (i_start) begin
                    r_key  <= i_key;
                    r_prod <= PROD_W'(i_key) * PROD_W'(RECIP);
                end
                if (r_stage) begin
                    r_home <= w_rem[IW-1:0];
                end
            end
        end
    endgenerate

    assign o_done = r_done;
    assign o_home = r_home;

endmodule

// File: src/cht_free_scan.sv
// ---------------------------------------------------------------------------
// cht_free_scan
// Free slot finder: steps through the slot valid bits one per cycle and
// stops at the lowest empty slot or at the end of the table.
// ---------------------------------------------------------------------------
module cht_free_scan
    import cht_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int IW         = $clog2(TABLE_SIZE)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [TABLE_SIZE-1:0] i_slot_valid,
    output logic                  o_done,
    output logic                  o_found,
    output logic [IW-1:0]         o_slot
);

    logic          r_run;
    logic          r_done;
    logic          r_found;
    logic [IW-1:0] r_idx;

    // one slot inspected per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
        end else if (i_start) begin
            r_run   <= 1'b1;
            r_done  <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
        end else if (r_run) begin
            if (!i_slot_valid[r_idx]) begin
                r_run   <= 1'b0;
                r_done  <= 1'b1;
                r_found <= 1'b1;
            end else if (r_idx == IW'(TABLE_SIZE - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign o_done  = r_done;
    assign o_found = r_found;
    assign o_slot  = r_idx;

endmodule

// File: src/cht_mem.sv
// ---------------------------------------------------------------------------
// cht_mem
// Record and link storage: two synchronous memories sharing one read
// address, each with one write port and a registered read.
// ---------------------------------------------------------------------------
module cht_mem
    import cht_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int IW         = $clog2(TABLE_SIZE)
) (
    input  logic          i_clk,
    input  logic [IW-1:0] i_rd_addr,
    input  logic          i_rec_we,
    input  logic [IW-1:0] i_rec_addr,
    input  t_record       i_rec_wdata,
    input  logic          i_link_we,
    input  logic [IW-1:0] i_link_addr,
    input  logic [IW-1:0] i_link_wdata,
    output t_record       o_rec_q,
    output logic [IW-1:0] o_link_q
);

    t_record       rec_mem  [TABLE_SIZE];
    logic [IW-1:0] link_mem [TABLE_SIZE];

    // record memory
    always_ff @(posedge i_clk) begin
        if (i_rec_we) begin
            rec_mem[i_rec_addr] <= i_rec_wdata;
        end
        o_rec_q <= rec_mem[i_rd_addr];
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (i_link_we) begin
            link_mem[i_link_addr] <= i_link_wdata;
        end
        o_link_q <= link_mem[i_rd_addr];
    end

endmodule

// File: src/cht_checker.sv
// ---------------------------------------------------------------------------
// cht_checker
// Port-level checks of the coalesced hash table command and result words.
// ---------------------------------------------------------------------------
module cht_checker
    import cht_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input logic [STATUS_W-1:0] o_status,
    input logic [VAL_W-1:0]    o_found_mood,
    input logic [VAL_W-1:0]    o_found_stress,
    input logic [TAG_W-1:0]    o_found_tag,
    input logic [SLOT_W-1:0]   o_slot_used
);

    // an accepted command keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // the result word is shown only when the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    // a command only finishes with a result word
    a_finish_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_done)
        else $error("command finished without a result");

    // record fields are zero unless a record was found
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_FOUND |->
            o_found_mood == '0 && o_found_stress == '0 && o_found_tag == '0)
        else $error("record fields set without a match");

    // full and not found carry no slot number
    a_zero_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == ST_FULL || o_status == ST_MISSING) |->
            o_slot_used == '0)
        else $error("slot number set on a failed command");

endmodule

bind coalesced_hash_table cht_checker u_cht_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_status       (o_status),
    .o_found_mood   (o_found_mood),
    .o_found_stress (o_found_stress),
    .o_found_tag    (o_found_tag),
    .o_slot_used    (o_slot_used)
);

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for coalesced_hash_table. A short table of commands
// covers the empty table, field extremes, chaining through occupied homes,
// coalesced chains, duplicate keys and the full table. Random commands
// follow. Every command word is run through a behavioral table model at the
// edge where it is accepted, and every result word is compared field by
// field against the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;
    import cht_pkg::*;

    localparam int TBL_SIZE    = DEF_TABLE_SIZE;
    localparam int RAND_WORDS  = 400;
    localparam int TAIL_CYCLES = 40;

    // one result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    mood;
        logic [VAL_W-1:0]    stress;
        logic [TAG_W-1:0]    tag;
        logic [SLOT_W-1:0]   slot;
    } t_reply;

    // one row of the directed command table
    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] mood;
        logic [VAL_W-1:0] stress;
        logic [TAG_W-1:0] tag;
        logic             pinned;
        t_reply           want;
    } t_row;

    localparam t_reply UNPINNED = '0;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_opcode;
    logic [KEY_W-1:0]    i_entry_key;
    logic [VAL_W-1:0]    i_mood_value;
    logic [VAL_W-1:0]    i_stress_value;
    logic [TAG_W-1:0]    i_time_tag;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [VAL_W-1:0]    o_found_mood;
    logic [VAL_W-1:0]    o_found_stress;
    logic [TAG_W-1:0]    o_found_tag;
    logic [SLOT_W-1:0]   o_slot_used;

    // shadow copy of the table contents
    logic              slot_taken [TBL_SIZE];
    t_record           slot_rec   [TBL_SIZE];
    logic              has_link   [TBL_SIZE];
    logic [SLOT_W-1:0] link_to    [TBL_SIZE];

    t_reply replies_due [$];
    int     error_count;

    // typed expectation for the word being offered, if any
    logic   pin_active;
    t_reply pin_reply;

    // directed commands: empty table, extremes, chaining, duplicates, full
    t_row plan [24] = '{
        '{OP_SEARCH, 16'h0000, 8'h00, 8'h00, 64'h0, 1'b1,
          '{ST_MISSING, 8'h00, 8'h00, 64'h0, 4'h0}},
        '{OP_INSERT, 16'h0000, 8'h00, 8'h00, 64'h0, 1'b1,
          '{ST_ADDED, 8'h00, 8'h00, 64'h0, 4'h0}},
        '{OP_INSERT, 16'hFFFF, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          '{ST_ADDED, 8'h00, 8'h00, 64'h0, 4'hF}},
        '{OP_SEARCH, 16'hFFFF, 8'h00, 8'h00, 64'h0, 1'b1,
          '{ST_FOUND, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF}},
        '{OP_SEARCH, 16'h0000, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          '{ST_FOUND, 8'h00, 8'h00, 64'h0, 4'h0}},
        // home 0 taken, so these start chaining
        '{OP_INSERT, 16'h0010, 8'h3C, 8'h5A, 64'h0123_4567_89AB_CDEF, 1'b0, UNPINNED},
        '{OP_INSERT, 16'h0001, 8'h81, 8'h42, 64'hFEDC_BA98_7654_3210, 1'b0, UNPINNED},
        '{OP_INSERT, 16'h0020, 8'h7E, 8'h01, 64'h8000_0000_0000_0001, 1'b0, UNPINNED},
        '{OP_SEARCH, 16'h0020, 8'h00, 8'h00, 64'h0, 1'b0, UNPINNED},
        '{OP_SEARCH, 16'h0030, 8'h00, 8'h00, 64'h0, 1'b0, UNPINNED},
        // duplicate key: the search must return the first one on the chain
        '{OP_INSERT, 16'h0010, 8'hA5, 8'hC3, 64'h5555_AAAA_5555_AAAA, 1'b0, UNPINNED},
        '{OP_SEARCH, 16'h0010, 8'h00, 8'h00, 64'h0, 1'b0, UNPINNED},
        // grow the chain from home 0 until every slot is taken
        '{OP_INSERT, 16'h0040, 8'h10, 8'hE0, 64'h0000_0000_0000_0040, 1'b0, UNPINNED},
        '{OP_INSERT, 16'h0050, 8'h11, 8'hE1, 64'h0000_0000_0000_0050, 1'b0, UNPINNED},
        '{OP_INSERT, 16'h0060, 8'h12, 8'hE2, 64'h0000_0000_0000_0060, 1'b0, UNPINNED},
        '{OP_INSERT, 16'h0070, 8'h13, 8'hE3, 64'h0000_0000_0000_0070, 1'b0, UNPINNED},
        '{OP_INSERT, 16'h0080, 8'h14, 8'hE4, 64'h0000_0000_0000_0080, 1'b0, UNPINNED},
        '{OP_INSERT, 16'h0090, 8'h15, 8'hE5, 64'h0000_0000_0000_0090, 1'b0, UNPINNED},
        '{OP_INSERT, 16'h00A0, 8'h16, 8'hE6, 64'h0000_0000_0000_00A0, 1'b0, UNPINNED},
        '{OP_INSERT, 16'h00B0, 8'h17, 8'hE7, 64'h0000_0000_0000_00B0, 1'b0, UNPINNED},
        '{OP_INSERT, 16'h00C0, 8'h18, 8'hE8, 64'h0000_0000_0000_00C0, 1'b0, UNPINNED},
        '{OP_INSERT, 16'h00D0, 8'h19, 8'hE9, 64'h0000_0000_0000_00D0, 1'b0, UNPINNED},
        '{OP_INSERT, 16'h7FFF, 8'hFF, 8'h00, 64'h0F0F_0F0F_F0F0_F0F0, 1'b1,
          '{ST_FULL, 8'h00, 8'h00, 64'h0, 4'h0}},
        // longest chain walk
        '{OP_SEARCH, 16'h00D0, 8'h00, 8'h00, 64'h0, 1'b0, UNPINNED}
    };

    coalesced_hash_table uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_entry_key    (i_entry_key),
        .i_mood_value   (i_mood_value),
        .i_stress_value (i_stress_value),
        .i_time_tag     (i_time_tag),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_found_mood   (o_found_mood),
        .o_found_stress (o_found_stress),
        .o_found_tag    (o_found_tag),
        .o_slot_used    (o_slot_used)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run the table model on one command word and return its result word
    function automatic t_reply table_apply(input logic op, input logic [KEY_W-1:0] key,
                                           input logic [VAL_W-1:0] mood,
                                           input logic [VAL_W-1:0] stress,
                                           input logic [TAG_W-1:0] tag);
        t_reply r;
        int     home;
        int     cur;
        int     target;
        r      = '0;
        home   = key % TBL_SIZE;
        cur    = home;
        target = -1;
        if (op == OP_INSERT) begin
            if (!slot_taken[home]) begin
                target = home;
            end else begin
                // walk to the end of the chain, then take the lowest free slot
                for (int n = 0; n < TBL_SIZE && has_link[cur]; n++)
                    cur = link_to[cur];
                for (int j = TBL_SIZE - 1; j >= 0; j--)
                    if (!slot_taken[j]) target = j;
                if (target < 0) begin
                    r.status = ST_FULL;
                    return r;
                end
                has_link[cur] = 1'b1;
                link_to[cur]  = SLOT_W'(target);
            end
            slot_taken[target]      = 1'b1;
            slot_rec[target].key    = key;
            slot_rec[target].mood   = mood;
            slot_rec[target].stress = stress;
            slot_rec[target].tag    = tag;
            has_link[target]        = 1'b0;
            r.status = ST_ADDED;
            r.slot   = SLOT_W'(target);
            return r;
        end
        // search: first match on the chain from the home slot
        r.status = ST_MISSING;
        if (!slot_taken[home])
            return r;
        for (int n = 0; n < TBL_SIZE; n++) begin
            if (slot_taken[cur] && slot_rec[cur].key == key) begin
                r.status = ST_FOUND;
                r.mood   = slot_rec[cur].mood;
                r.stress = slot_rec[cur].stress;
                r.tag    = slot_rec[cur].tag;
                r.slot   = SLOT_W'(cur);
                return r;
            end
            if (!has_link[cur])
                return r;
            cur = link_to[cur];
        end
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [TAG_W-1:0] want,
                                        input logic [TAG_W-1:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    // idle length before the next word: mostly short, a few long
    function automatic int pick_gap(input logic burst);
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 35)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // offer one command word and hold it until it is taken
    task automatic issue_cmd(input logic op, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] mood, input logic [VAL_W-1:0] stress,
                             input logic [TAG_W-1:0] tag, input logic pinned,
                             input t_reply want, input logic burst);
        int gap;
        gap = pick_gap(burst);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pin_active     = pinned;
        pin_reply      = want;
        start          <= 1'b1;
        i_opcode       <= op;
        i_entry_key    <= key;
        i_mood_value   <= mood;
        i_stress_value <= stress;
        i_time_tag     <= tag;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // result check and prediction at each accepted word
    always @(posedge i_clk) begin
        t_reply seen;
        t_reply due;
        t_reply guess;
        if (i_rst_n) begin
            if (o_done) begin
                seen = '{o_status, o_found_mood, o_found_stress, o_found_tag, o_slot_used};
                if (replies_due.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result word, expected none, got %0h",
                             $time, seen);
                end else begin
                    due = replies_due.pop_front();
                    check_field("status", TAG_W'(due.status), TAG_W'(seen.status));
                    check_field("found_mood", TAG_W'(due.mood), TAG_W'(seen.mood));
                    check_field("found_stress", TAG_W'(due.stress), TAG_W'(seen.stress));
                    check_field("found_tag", due.tag, seen.tag);
                    check_field("slot_used", TAG_W'(due.slot), TAG_W'(seen.slot));
                end
            end
            if (start && !busy) begin
                guess = table_apply(i_opcode, i_entry_key, i_mood_value,
                                    i_stress_value, i_time_tag);
                replies_due.push_back(pin_active ? pin_reply : guess);
            end
        end
    end

    // stimulus
    initial begin
        logic             burst;
        logic             op;
        logic [KEY_W-1:0] key;
        int               kind;
        error_count    = 0;
        pin_active     = 1'b0;
        pin_reply      = '0;
        for (int s = 0; s < TBL_SIZE; s++) begin
            slot_taken[s] = 1'b0;
            has_link[s]   = 1'b0;
        end
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_opcode       <= OP_INSERT;
        i_entry_key    <= '0;
        i_mood_value   <= '0;
        i_stress_value <= '0;
        i_time_tag     <= '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (plan[r])
            issue_cmd(plan[r].op, plan[r].key, plan[r].mood, plan[r].stress,
                      plan[r].tag, plan[r].pinned, plan[r].want, 1'b0);

        // random words; the table is full now, so searches do the real work
        burst = 1'b0;
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n % 32 == 0)
                burst = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            op   = OP_SEARCH;
            if (kind < 45) begin
                // hit somewhere along a chain
                key = slot_rec[$urandom_range(0, TBL_SIZE - 1)].key;
            end else if (kind < 65) begin
                // near miss: one key bit flipped
                key = slot_rec[$urandom_range(0, TBL_SIZE - 1)].key
                      ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
            end else if (kind < 80) begin
                key = KEY_W'($urandom_range(0, 65535));
            end else begin
                op  = OP_INSERT;
                key = KEY_W'($urandom_range(0, 65535));
            end
            issue_cmd(op, key, VAL_W'($urandom_range(0, 255)),
                      VAL_W'($urandom_range(0, 255)), {$urandom, $urandom},
                      1'b0, UNPINNED, burst);
        end
        start <= 1'b0;

        // drain outstanding results, then let the block settle
        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && replies_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
